>>> rtl/assert_macros.svh
// assertion macros shared by the rtl of the pec transaction checker
// expects clk and rst_n in the scope of each use; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/spc_pkg.sv
// types, codes and crc-8 table for the smbus pec transaction checker
// no dependencies
`timescale 1ns / 1ps

package spc_pkg;

  localparam int unsigned MaxBlockDef = 32;
  localparam logic [5:0]  CntMax      = 6'd63;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_END   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ATTR  = 3'd1,
    ST_LEN   = 3'd2,
    ST_UNSUP = 3'd3,
    ST_CRC   = 3'd4
  } status_t;

  localparam logic [3:0] PROTO_QUICK_WR   = 4'd0;
  localparam logic [3:0] PROTO_QUICK_RD   = 4'd1;
  localparam logic [3:0] PROTO_SEND_BYTE  = 4'd2;
  localparam logic [3:0] PROTO_RECV_BYTE  = 4'd3;
  localparam logic [3:0] PROTO_WR_BYTE    = 4'd4;
  localparam logic [3:0] PROTO_RD_BYTE    = 4'd5;
  localparam logic [3:0] PROTO_WR_WORD    = 4'd6;
  localparam logic [3:0] PROTO_RD_WORD    = 4'd7;
  localparam logic [3:0] PROTO_WR_BLOCK   = 4'd8;
  localparam logic [3:0] PROTO_RD_BLOCK   = 4'd9;
  localparam logic [3:0] PROTO_PROC_CALL  = 4'd10;
  localparam logic [3:0] PROTO_BLK_PROC   = 4'd11;

  // flag bits: read phase, length from device, pec enabled
  typedef struct packed {
    logic pec;
    logic rlen;
    logic rd;
  } flags_t;

  typedef struct packed {
    logic       done;
    logic       append;
    logic [7:0] pec;
    status_t    status;
  } res_t;

  // crc-8 poly 0x07 of a nibble placed in the lower half
  function automatic logic [7:0] nib_tab(input logic [3:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'h0: v = 8'h00;
      4'h1: v = 8'h07;
      4'h2: v = 8'h0E;
      4'h3: v = 8'h09;
      4'h4: v = 8'h1C;
      4'h5: v = 8'h1B;
      4'h6: v = 8'h12;
      4'h7: v = 8'h15;
      4'h8: v = 8'h38;
      4'h9: v = 8'h3F;
      4'hA: v = 8'h36;
      4'hB: v = 8'h31;
      4'hC: v = 8'h24;
      4'hD: v = 8'h23;
      4'hE: v = 8'h2A;
      default: v = 8'h2D;
    endcase
    return v;
  endfunction

  function automatic status_t check_flags(input logic [3:0] p, input flags_t f);
    status_t s;
    unique case (p)
      PROTO_QUICK_WR, PROTO_QUICK_RD:
        s = (f.rd || f.rlen || f.pec) ? ST_ATTR : ST_OK;
      PROTO_SEND_BYTE, PROTO_WR_BYTE, PROTO_WR_WORD, PROTO_WR_BLOCK:
        s = (f.rd || f.rlen) ? ST_ATTR : ST_OK;
      PROTO_RD_BLOCK, PROTO_BLK_PROC:
        s = (f.rd && f.rlen) ? ST_OK : ST_ATTR;
      PROTO_RECV_BYTE, PROTO_RD_BYTE, PROTO_RD_WORD, PROTO_PROC_CALL:
        s = (f.rd && !f.rlen) ? ST_OK : ST_ATTR;
      default:
        s = ST_UNSUP;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/smbus_pec_transaction_checker_top.sv
// result: each accepted word gives a result word, registered in out_r or skid_r
// throughput: one word per cycle while skid_r is empty; a result register plus
// a skid stage keep the input open while one result waits; the crc update is two folds deep
// reset: rst_n synchronous active low clears transaction state and valids
// top level of the smbus pec transaction checker; uses spc_pkg, spc_crc8_fold
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smbus_pec_transaction_checker_top #(
  parameter int unsigned MAX_BLOCK = spc_pkg::MaxBlockDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // protocol[3:0], address[10:4], is_read[11], recv_len[12], pec_on[13],
  // data_byte[21:14], zero[23:22]
  input  logic [23:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], pec_value[10:3], pec_append[11], zero[15:12]
  output logic [15:0] out_tdata,
  // done_res[0]
  output logic        out_tuser
);
  import spc_pkg::*;

  localparam logic [7:0] MaxBlk  = 8'(MAX_BLOCK);
  localparam logic [8:0] MaxBlk9 = 9'(MAX_BLOCK);

  // transaction state
  logic [3:0] proto_r,  proto_nxt;
  logic [6:0] addr_r,   addr_nxt;
  flags_t     flags_r,  flags_nxt;
  logic [7:0] crc_r,    crc_nxt;
  logic [5:0] wcnt_r,   wcnt_nxt;
  logic [5:0] rcnt_r,   rcnt_nxt;
  logic [7:0] bcw_r,    bcw_nxt;
  logic [7:0] bcr_r,    bcr_nxt;
  logic       rps_r,    rps_nxt;
  status_t    pend_r,   pend_nxt;

  // output register and skid stage
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  req_t       req;
  logic [3:0] in_proto;
  logic [6:0] in_addr;
  flags_t     in_flags;
  logic [7:0] in_byte;
  logic       push, pop;
  res_t       res;

  logic [7:0] fa_crc, fa_byte, fa_out;
  logic [7:0] fb_crc, fb_out;
  logic       len_ok;
  logic [7:0] w_less2;
  logic [8:0] bsum;

  assign req      = req_t'(in_tuser);
  assign in_proto = in_tdata[3:0];
  assign in_addr  = in_tdata[10:4];
  assign in_flags = '{pec: in_tdata[13], rlen: in_tdata[12], rd: in_tdata[11]};
  assign in_byte  = in_tdata[21:14];

  assign in_tready = !skid_valid_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;

  // first fold: start address byte on begin, read address byte before first read
  assign fa_crc  = (req == REQ_BEGIN) ? 8'h00 : crc_r;
  assign fa_byte = (req == REQ_BEGIN) ? {in_addr, 1'b0} : {addr_r, 1'b1};
  assign fb_crc  = (req == REQ_READ && !rps_r) ? fa_out : crc_r;

  spc_crc8_fold u_fold_a (
    .crc_in  (fa_crc),
    .byte_in (fa_byte),
    .crc_out (fa_out)
  );

  spc_crc8_fold u_fold_b (
    .crc_in  (fb_crc),
    .byte_in (in_byte),
    .crc_out (fb_out)
  );

  assign w_less2 = {2'b00, wcnt_r - 6'd2};
  assign bsum    = {1'b0, bcw_r} + {1'b0, bcr_r};

  always_comb begin
    unique case (proto_r)
      PROTO_QUICK_WR, PROTO_QUICK_RD: len_ok = (wcnt_r == 6'd0) && (rcnt_r == 6'd0);
      PROTO_SEND_BYTE:  len_ok = (wcnt_r == 6'd1) && (rcnt_r == 6'd0);
      PROTO_RECV_BYTE:  len_ok = (wcnt_r == 6'd0) && (rcnt_r == 6'd1);
      PROTO_WR_BYTE:    len_ok = (wcnt_r == 6'd2) && (rcnt_r == 6'd0);
      PROTO_RD_BYTE:    len_ok = (wcnt_r == 6'd1) && (rcnt_r == 6'd1);
      PROTO_WR_WORD:    len_ok = (wcnt_r == 6'd3) && (rcnt_r == 6'd0);
      PROTO_RD_WORD:    len_ok = (wcnt_r == 6'd1) && (rcnt_r == 6'd2);
      PROTO_WR_BLOCK:
        len_ok = (wcnt_r >= 6'd3) && (rcnt_r == 6'd0) && (w_less2 == bcw_r) &&
                 (bcw_r <= MaxBlk);
      PROTO_RD_BLOCK:
        len_ok = (wcnt_r == 6'd1) && (rcnt_r != 6'd0) && (bcr_r <= MaxBlk);
      PROTO_PROC_CALL:  len_ok = (wcnt_r == 6'd3) && (rcnt_r == 6'd2);
      PROTO_BLK_PROC:
        len_ok = (wcnt_r >= 6'd3) && (rcnt_r != 6'd0) && (w_less2 == bcw_r) &&
                 (bcw_r <= MaxBlk) && (bsum <= MaxBlk9);
      default:          len_ok = 1'b0;
    endcase
  end

  always_comb begin
    proto_nxt  = proto_r;
    addr_nxt   = addr_r;
    flags_nxt  = flags_r;
    crc_nxt    = crc_r;
    wcnt_nxt   = wcnt_r;
    rcnt_nxt   = rcnt_r;
    bcw_nxt    = bcw_r;
    bcr_nxt    = bcr_r;
    rps_nxt    = rps_r;
    pend_nxt   = pend_r;
    res.status = pend_r;
    res.append = 1'b0;
    res.done   = 1'b0;
    unique case (req)
      REQ_BEGIN: begin
        proto_nxt  = in_proto;
        addr_nxt   = in_addr;
        flags_nxt  = in_flags;
        wcnt_nxt   = '0;
        rcnt_nxt   = '0;
        bcw_nxt    = '0;
        bcr_nxt    = '0;
        rps_nxt    = 1'b0;
        // receive byte starts with the read address, folded on its first byte
        crc_nxt    = (in_proto == PROTO_RECV_BYTE) ? 8'h00 : fa_out;
        pend_nxt   = check_flags(in_proto, in_flags);
        res.status = pend_nxt;
      end
      REQ_WRITE: begin
        crc_nxt = fb_out;
        if (wcnt_r == 6'd1) begin
          bcw_nxt = in_byte;
        end
        if (wcnt_r < CntMax) begin
          wcnt_nxt = wcnt_r + 6'd1;
        end
      end
      REQ_READ: begin
        crc_nxt = fb_out;
        rps_nxt = 1'b1;
        if (rcnt_r == 6'd0) begin
          bcr_nxt = in_byte;
        end
        if (rcnt_r < CntMax) begin
          rcnt_nxt = rcnt_r + 6'd1;
        end
      end
      default: begin
        res.done = 1'b1;
        if (pend_r == ST_OK) begin
          if (!len_ok) begin
            res.status = ST_LEN;
          end else if (flags_r.pec) begin
            if (flags_r.rd) begin
              if (crc_r != in_byte) begin
                res.status = ST_CRC;
              end
            end else begin
              res.append = 1'b1;
            end
          end
        end
      end
    endcase
    res.pec = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r <= '0;
      addr_r  <= '0;
      flags_r <= '0;
      crc_r   <= '0;
      wcnt_r  <= '0;
      rcnt_r  <= '0;
      bcw_r   <= '0;
      bcr_r   <= '0;
      rps_r   <= 1'b0;
      pend_r  <= ST_OK;
    end else if (push) begin
      proto_r <= proto_nxt;
      addr_r  <= addr_nxt;
      flags_r <= flags_nxt;
      crc_r   <= crc_nxt;
      wcnt_r  <= wcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      bcw_r   <= bcw_nxt;
      bcr_r   <= bcr_nxt;
      rps_r   <= rps_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // result register with skid: a new result arriving while out_r is stalled parks in skid_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_r.append, out_r.pec, out_r.status};
  assign out_tuser  = out_r.done;

  `ASSERT_IMPLIES(a_skid_behind_out, skid_valid_r, out_valid_r)
  `ASSERT_IMPLIES(a_append_only_ok_end, out_valid_r && out_r.append,
                  out_r.done && (out_r.status == ST_OK))
  `ASSERT_IMPLIES(a_mismatch_only_end, out_valid_r && (out_r.status == ST_CRC), out_r.done)
  `ASSERT_NEXT(a_stall_no_push, skid_valid_r && !out_tready, skid_valid_r && out_valid_r)

endmodule

>>> rtl/spc_crc8_fold.sv
// folds one byte into the smbus pec crc-8 (poly 0x07), two nibble lookups
// depends on spc_pkg for the nibble table
`timescale 1ns / 1ps

module spc_crc8_fold (
  input  logic [7:0] crc_in,
  input  logic [7:0] byte_in,
  output logic [7:0] crc_out
);
  import spc_pkg::*;

  logic [7:0] t;
  logic [7:0] c;

  always_comb begin
    t       = crc_in ^ byte_in;
    c       = nib_tab(t[7:4]);
    crc_out = {c[3:0], 4'h0} ^ nib_tab(c[7:4] ^ t[3:0]);
  end

endmodule
